// File: hw/rtl/bcd_pkg.sv
package bcd_pkg;

	// block format register codes, the unused code decodes as bc3
	localparam logic [1:0] FMT_BC1 = 2'd0;
	localparam logic [1:0] FMT_BC2 = 2'd1;
	localparam logic [1:0] FMT_BC3 = 2'd2;

	localparam int unsigned NUM_PIX  = 16;
	localparam int unsigned PIX_BITS = 4;
	localparam int unsigned Q_DEPTH  = 2;

	// one compressed block as it arrives
	typedef struct packed {
		logic [63:0] block_low;
		logic [63:0] block_high;
	} blk_in_t;

	// one decoded pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [3:0] pixel_index;
		logic       last;
	} pix_out_t;

	// classified block with its palettes, as held in the queue
	typedef struct packed {
		logic [1:0]        fmt;
		logic              opaque;
		logic [3:0][23:0]  cpal;
		logic [7:0][7:0]   apal;
		logic [31:0]       cidx;
		logic [63:0]       abits;
	} bcd_entry_t;

	// front to queue
	typedef struct packed {
		logic       push;
		bcd_entry_t entry;
	} bcd_qwr_t;

	// queue to back
	typedef struct packed {
		logic       valid;
		bcd_entry_t entry;
	} bcd_qhead_t;

	// 565 endpoint to 888 by bit replication, packed as {r, g, b}
	function automatic logic [23:0] expand565(input logic [15:0] c);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] b;
		r = c[15:11];
		g = c[10:5];
		b = c[4:0];
		return {r, r[4:2], g, g[5:4], b, b[4:2]};
	endfunction

	// floor(x / 3) for x up to 765, reciprocal multiply
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'd21846;
		return p[23:16];
	endfunction

	// floor(x / 5) for x up to 1275
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [23:0] p;
		p = 24'(x) * 24'd6554;
		return p[22:15];
	endfunction

	// floor(x / 7) for x up to 1785
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [23:0] p;
		p = 24'(x) * 24'd4682;
		return p[22:15];
	endfunction

endpackage

// File: hw/rtl/bc_block_decode.sv
// channel   direction  handshake             beat
// blk       in         blk_valid/blk_stall   one compressed block (low and high halves)
// pix       out        pix_valid/pix_stall   one rgba8 pixel with index and last flag
// cfg       in         cfg_valid/cfg_ready   block format code
//
// the pixel sequencer in the back part emits one pixel a cycle while a block waits and pix is not stalled.
// the first pixel passes through capture, palette stage, queue and out reg after the block beat.
// a two-entry queue lets the front take the next block while the back still emits pixels.
// arst_n clears all valids, the queue and the format register (format resets to bc1).
// a stall on pix holds the output register; blk stalls only when the front stages are full.
module bc_block_decode import bcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       blk_valid,
	output logic       blk_stall,
	input  blk_in_t    blk,
	output logic       pix_valid,
	input  logic       pix_stall,
	output pix_out_t   pix,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	logic [1:0] fmt_q;
	bcd_qwr_t   qwr;
	bcd_qhead_t head;
	logic       q_full;
	logic       pop;

	// format register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_BC1;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_data;
		end
	end

	// classify and build palettes
	bcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk       (blk),
		.fmt       (fmt_q),
		.q_full    (q_full),
		.qwr       (qwr)
	);

	// decoupling queue
	bcd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	// pixel sequencer
	bcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix)
	);

endmodule

// File: hw/rtl/bcd_front.sv
module bcd_front import bcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       blk_valid,
	output logic       blk_stall,
	input  blk_in_t    blk,
	input  logic [1:0] fmt,
	input  logic       q_full,
	output bcd_qwr_t   qwr
);

	// stage 1: captured beat
	logic       vld_s1;
	blk_in_t    blk_s1;
	logic [1:0] fmt_s1;

	// stage 2: weighted sums
	logic             vld_s2;
	logic [1:0]       fmt_s2;
	logic             opaque_s2;
	logic             agt_s2;
	logic [23:0]      ep0_s2;
	logic [23:0]      ep1_s2;
	logic [2:0][9:0]  sum2_s2;
	logic [2:0][9:0]  sum3_s2;
	logic [2:0][8:0]  sumh_s2;
	logic [5:0][10:0] w7_s2;
	logic [3:0][10:0] w5_s2;
	logic [7:0]       a0_s2;
	logic [7:0]       a1_s2;
	logic [31:0]      cidx_s2;
	logic [63:0]      abits_s2;

	logic push;
	logic s1_adv;
	logic s1_load;

	// stage 1 decode
	logic             bc1_c;
	logic [63:0]      chalf_c;
	logic [23:0]      ep0_c;
	logic [23:0]      ep1_c;
	logic             opaque_c;
	logic [2:0][9:0]  sum2_c;
	logic [2:0][9:0]  sum3_c;
	logic [2:0][8:0]  sumh_c;
	logic [5:0][10:0] w7_c;
	logic [3:0][10:0] w5_c;
	logic [7:0]       a0_c;
	logic [7:0]       a1_c;

	// stage 2 palette build
	bcd_entry_t entry_c;

	// handshake along the two stages
	assign push      = vld_s2 && !q_full;
	assign s1_adv    = vld_s1 && (!vld_s2 || push);
	assign s1_load   = !vld_s1 || s1_adv;
	assign blk_stall = !s1_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				vld_s1 <= blk_valid;
			end
			if (s1_adv) begin
				vld_s2 <= 1'b1;
			end else if (push) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && blk_valid) begin
			blk_s1 <= blk;
			fmt_s1 <= fmt;
		end
	end

	// endpoints, colour mode and weighted sums
	always_comb begin
		bc1_c    = (fmt_s1 == FMT_BC1);
		chalf_c  = bc1_c ? blk_s1.block_low : blk_s1.block_high;
		ep0_c    = expand565(chalf_c[15:0]);
		ep1_c    = expand565(chalf_c[31:16]);
		opaque_c = !bc1_c || (chalf_c[15:0] > chalf_c[31:16]);
		for (int ch = 0; ch < 3; ch++) begin
			sum2_c[ch] = {1'b0, ep0_c[ch*8 +: 8], 1'b0} + {2'b00, ep1_c[ch*8 +: 8]};
			sum3_c[ch] = {2'b00, ep0_c[ch*8 +: 8]} + {1'b0, ep1_c[ch*8 +: 8], 1'b0};
			sumh_c[ch] = {1'b0, ep0_c[ch*8 +: 8]} + {1'b0, ep1_c[ch*8 +: 8]};
		end
		a0_c = blk_s1.block_low[7:0];
		a1_c = blk_s1.block_low[15:8];
		for (int i = 0; i < 6; i++) begin
			w7_c[i] = 11'(6 - i) * {3'b000, a0_c} + 11'(1 + i) * {3'b000, a1_c};
		end
		for (int i = 0; i < 4; i++) begin
			w5_c[i] = 11'(4 - i) * {3'b000, a0_c} + 11'(1 + i) * {3'b000, a1_c};
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			fmt_s2    <= fmt_s1;
			opaque_s2 <= opaque_c;
			agt_s2    <= a0_c > a1_c;
			ep0_s2    <= ep0_c;
			ep1_s2    <= ep1_c;
			sum2_s2   <= sum2_c;
			sum3_s2   <= sum3_c;
			sumh_s2   <= sumh_c;
			w7_s2     <= w7_c;
			w5_s2     <= w5_c;
			a0_s2     <= a0_c;
			a1_s2     <= a1_c;
			cidx_s2   <= chalf_c[63:32];
			abits_s2  <= blk_s1.block_low;
		end
	end

	// palettes from the sums, divisions by reciprocal
	always_comb begin
		entry_c.fmt     = fmt_s2;
		entry_c.opaque  = opaque_s2;
		entry_c.cidx    = cidx_s2;
		entry_c.abits   = abits_s2;
		entry_c.cpal[0] = ep0_s2;
		entry_c.cpal[1] = ep1_s2;
		for (int ch = 0; ch < 3; ch++) begin
			if (opaque_s2) begin
				entry_c.cpal[2][ch*8 +: 8] = div3(sum2_s2[ch]);
				entry_c.cpal[3][ch*8 +: 8] = div3(sum3_s2[ch]);
			end else begin
				entry_c.cpal[2][ch*8 +: 8] = sumh_s2[ch][8:1];
				entry_c.cpal[3][ch*8 +: 8] = 8'd0;
			end
		end
		entry_c.apal[0] = a0_s2;
		entry_c.apal[1] = a1_s2;
		for (int i = 0; i < 6; i++) begin
			if (agt_s2) begin
				entry_c.apal[2 + i] = div7(w7_s2[i]);
			end else if (i < 4) begin
				entry_c.apal[2 + i] = div5(w5_s2[i]);
			end else if (i == 4) begin
				entry_c.apal[2 + i] = 8'd0;
			end else begin
				entry_c.apal[2 + i] = 8'd255;
			end
		end
	end

	assign qwr.push  = push;
	assign qwr.entry = entry_c;

endmodule

// File: hw/rtl/bcd_queue.sv
module bcd_queue import bcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bcd_qwr_t   qwr,
	input  logic       pop,
	output logic       full,
	output bcd_qhead_t head
);

	bcd_entry_t mem [Q_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'(Q_DEPTH));
	assign head.valid = (cnt_q != 2'd0);
	assign head.entry = mem[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (qwr.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (qwr.push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !qwr.push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (qwr.push) begin
			mem[wr_ptr_q] <= qwr.entry;
		end
	end

	// no write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qwr.push |-> !full)
		else $error("queue write while full");

	// no read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue read while empty");

endmodule

// File: hw/rtl/bcd_back.sv
module bcd_back import bcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bcd_qhead_t head,
	output logic       pop,
	output logic       pix_valid,
	input  logic       pix_stall,
	output pix_out_t   pix
);

	logic [PIX_BITS-1:0] cnt_q;
	logic                pix_valid_q;
	pix_out_t            pix_q;

	logic       fire;
	logic [1:0] ci;
	logic [3:0] a4;
	logic [2:0] ai;
	logic [5:0] aoff;
	logic [7:0] alpha_c;
	pix_out_t   pix_c;

	assign fire = head.valid && (!pix_valid_q || !pix_stall);
	assign pop  = fire && (cnt_q == PIX_BITS'(NUM_PIX - 1));

	// one pixel from the head block
	always_comb begin
		ci   = head.entry.cidx[{cnt_q, 1'b0} +: 2];
		a4   = head.entry.abits[{cnt_q, 2'b00} +: 4];
		aoff = 6'd16 + 6'(cnt_q) * 6'd3;
		ai   = head.entry.abits[aoff +: 3];
		case (head.entry.fmt)
			FMT_BC1: alpha_c = (ci == 2'd3 && !head.entry.opaque) ? 8'd0 : 8'd255;
			FMT_BC2: alpha_c = {a4, a4};
			default: alpha_c = head.entry.apal[ai];
		endcase
		pix_c.red         = head.entry.cpal[ci][23:16];
		pix_c.green       = head.entry.cpal[ci][15:8];
		pix_c.blue        = head.entry.cpal[ci][7:0];
		pix_c.alpha       = alpha_c;
		pix_c.pixel_index = cnt_q;
		pix_c.last        = (cnt_q == PIX_BITS'(NUM_PIX - 1));
	end

	// pixel counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cnt_q <= cnt_q + PIX_BITS'(1);
			end
			if (fire) begin
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (fire) begin
			pix_q <= pix_c;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	// the last flag marks exactly pixel fifteen
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid_q |-> (pix_q.last == (pix_q.pixel_index == PIX_BITS'(NUM_PIX - 1))))
		else $error("last flag out of place");

	// the counter wraps to the first pixel when a block is retired
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (cnt_q == '0))
		else $error("pixel counter did not wrap");

	// a new output beat carries the index the counter held
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (pix_q.pixel_index == $past(cnt_q)))
		else $error("pixel index mismatch");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import bcd_pkg::*;

	// the spare format code decodes like bc3
	localparam logic [1:0]  FMT_SPARE    = 2'd3;
	localparam int          RAND_PHASES  = 6;
	localparam int          PHASE_BLOCKS = 19;
	localparam logic [63:0] ONES         = '1;

	typedef enum int {ST_NONE, ST_COIN, ST_PERIODIC, ST_HEAVY} stall_mode_t;

	// one directed block: format, both halves, and a uniform pixel where it is obvious
	typedef struct packed {
		logic [1:0]  fmt;
		logic [63:0] lo;
		logic [63:0] hi;
		logic        typed;
		logic [31:0] rgba;
	} blk_vec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       blk_valid = 1'b0;
	logic       blk_stall;
	blk_in_t    blk = '0;
	logic       pix_valid;
	logic       pix_stall = 1'b0;
	pix_out_t   pix;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data = '0;

	pix_out_t    pending_pixels[$];
	logic [1:0]  fmt_now = FMT_BC1;
	int          mismatches = 0;
	int          burst_left = 0;
	stall_mode_t stall_mode = ST_NONE;
	int          stall_left = 0;
	int          stall_phase = 0;

	// uniform rows: all zero, all one; index patterns 0..3 per byte and 0..7 per 3-bit field
	blk_vec_t dir_tab [19] = '{
		'{FMT_BC1,   64'h0,                     64'h0,                     1'b1, 32'h0000_00FF},
		'{FMT_BC1,   ONES,                      ONES,                      1'b1, 32'h0000_0000},
		'{FMT_BC1,   64'hE4E4E4E4_0000FFFF,     64'h0,                     1'b0, 32'h0},
		'{FMT_BC1,   64'hE4E4E4E4_FFFF0000,     64'h0,                     1'b0, 32'h0},
		'{FMT_BC1,   64'h1B1B1B1B_F81FF81F,     64'h0,                     1'b0, 32'h0},
		'{FMT_BC1,   64'hE4E4E4E4_0000FFFF,     64'h0123456789ABCDEF,      1'b0, 32'h0},
		'{FMT_BC2,   64'h0,                     64'h0,                     1'b1, 32'h0000_0000},
		'{FMT_BC2,   ONES,                      ONES,                      1'b1, 32'hFFFF_FFFF},
		'{FMT_BC2,   64'hFEDCBA9876543210,      64'hE4E4E4E4_FFFF0000,     1'b0, 32'h0},
		'{FMT_BC2,   64'h0123456789ABCDEF,      64'h1B1B1B1B_07E0F800,     1'b0, 32'h0},
		'{FMT_BC3,   64'h0,                     64'h0,                     1'b1, 32'h0000_0000},
		'{FMT_BC3,   ONES,                      ONES,                      1'b1, 32'hFFFF_FFFF},
		'{FMT_BC3,   64'hFAC688FAC688_10F0,     64'hE4E4E4E4_001FFFE0,     1'b0, 32'h0},
		'{FMT_BC3,   64'hFAC688FAC688_F010,     64'h1B1B1B1B_FFE0001F,     1'b0, 32'h0},
		'{FMT_BC3,   64'hFAC688FAC688_8080,     64'hE4E4E4E4_80108010,     1'b0, 32'h0},
		'{FMT_SPARE, 64'hFAC688FAC688_10F0,     64'hE4E4E4E4_001FFFE0,     1'b0, 32'h0},
		'{FMT_SPARE, 64'hFAC688FAC688_F010,     64'hE4E4E4E4_FFFF0000,     1'b0, 32'h0},
		'{FMT_SPARE, ONES,                      ONES,                      1'b1, 32'hFFFF_FFFF},
		'{FMT_BC1,   64'h55AA55AA_7BEF8410,     64'hFFFF0000FFFF0000,      1'b0, 32'h0}
	};

	bc_block_decode dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk       (blk),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// run limit
	initial begin
		#3_200_000;
		$display("FAIL");
		$finish;
	end

	// 5 or 6 bit endpoint channel widened to 8 bits by repeating its top bits
	function automatic int widen(input int v, input int bits);
		return (bits == 5) ? ((v << 3) | (v >> 2)) : ((v << 2) | (v >> 4));
	endfunction

	// append one expected pixel at the tail of the pending list
	function automatic void queue_pixel(input pix_out_t px);
		pending_pixels = {pending_pixels, px};
	endfunction

	// decode one block into sixteen pending pixels
	function automatic void decode_block(input logic [1:0] fmt, input logic [63:0] lo,
			input logic [63:0] hi);
		logic [63:0] colour;
		logic        bc1;
		logic        opaque;
		int          c0, c1, e, a0, a1, ci, av;
		int          pal [4][4];
		int          apal [8];
		pix_out_t    px;
		bc1 = (fmt == FMT_BC1);
		colour = bc1 ? lo : hi;
		c0 = int'(colour[15:0]);
		c1 = int'(colour[31:16]);
		opaque = !bc1 || (c0 > c1);
		// endpoints
		for (int k = 0; k < 2; k++) begin
			e = k ? c1 : c0;
			pal[k][0] = widen((e >> 11) & 'h1F, 5);
			pal[k][1] = widen((e >> 5) & 'h3F, 6);
			pal[k][2] = widen(e & 'h1F, 5);
			pal[k][3] = 255;
		end
		// thirds, or half plus transparent black in punch-through
		for (int ch = 0; ch < 3; ch++) begin
			if (opaque) begin
				pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
				pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
			end else begin
				pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
				pal[3][ch] = 0;
			end
		end
		pal[2][3] = 255;
		pal[3][3] = opaque ? 255 : 0;
		// interpolated alpha palette
		a0 = int'(lo[7:0]);
		a1 = int'(lo[15:8]);
		apal[0] = a0;
		apal[1] = a1;
		if (a0 > a1) begin
			for (int i = 0; i < 6; i++)
				apal[2 + i] = ((6 - i) * a0 + (1 + i) * a1) / 7;
		end else begin
			for (int i = 0; i < 4; i++)
				apal[2 + i] = ((4 - i) * a0 + (1 + i) * a1) / 5;
			apal[6] = 0;
			apal[7] = 255;
		end
		// pixels in row-major order
		for (int p = 0; p < 16; p++) begin
			ci = int'(colour[32 + 2 * p +: 2]);
			if (bc1) begin
				av = pal[ci][3];
			end else if (fmt == FMT_BC2) begin
				av = int'(lo[4 * p +: 4]) * 17;
			end else begin
				av = apal[lo[16 + 3 * p +: 3]];
			end
			px.red = 8'(pal[ci][0]);
			px.green = 8'(pal[ci][1]);
			px.blue = 8'(pal[ci][2]);
			px.alpha = 8'(av);
			px.pixel_index = 4'(p);
			px.last = (p == 15);
			queue_pixel(px);
		end
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// compare each pixel beat with the oldest pending pixel
	always @(posedge clk) begin : pixel_check
		pix_out_t want;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel beat with nothing pending: index %0d", pix.pixel_index);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("red", want.red, pix.red);
				check_field("green", want.green, pix.green);
				check_field("blue", want.blue, pix.blue);
				check_field("alpha", want.alpha, pix.alpha);
				check_field("pixel_index", want.pixel_index, pix.pixel_index);
				check_field("last", want.last, pix.last);
			end
		end
	end

	// receiver stall pattern, switching to a new random mode whenever its random run ends
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			ST_NONE:     pix_stall <= 1'b0;
			ST_COIN:     pix_stall <= ($urandom_range(0, 1) == 0);
			ST_PERIODIC: pix_stall <= (stall_phase % 5 == 4);
			default:     pix_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// one block beat, then burst or gap handling
	task automatic send_block(input logic [63:0] lo, input logic [63:0] hi, input logic typed,
			input logic [31:0] rgba);
		pix_out_t px;
		blk <= '{block_low: lo, block_high: hi};
		blk_valid <= 1'b1;
		@(posedge clk);
		while (blk_stall) @(posedge clk);
		if (typed) begin
			for (int p = 0; p < 16; p++) begin
				px = '{red: rgba[31:24], green: rgba[23:16], blue: rgba[15:8],
					alpha: rgba[7:0], pixel_index: 4'(p), last: (p == 15)};
				queue_pixel(px);
			end
		end else begin
			decode_block(fmt_now, lo, hi);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			blk_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	// hold off the sender until every pending pixel has come out
	task automatic drain_pixels();
		blk_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_format(input logic [1:0] code);
		drain_pixels();
		cfg_valid <= 1'b1;
		cfg_data <= code;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		fmt_now = code;
	endtask

	// stimulus
	initial begin
		blk_vec_t    row;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [1:0]  code;
		logic [1:0]  fmt_order [4];
		fmt_order = '{FMT_BC2, FMT_SPARE, FMT_BC1, FMT_BC3};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, first rows use the format left by reset
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.fmt != fmt_now) begin
				write_format(row.fmt);
			end
			send_block(row.lo, row.hi, row.typed, row.rgba);
		end

		// random phases, each under one format
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			code = (ph < 4) ? fmt_order[ph] : 2'($urandom_range(0, 3));
			write_format(code);
			for (int n = 0; n < PHASE_BLOCKS; n++) begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
				// bias toward equal endpoints, which switch palette modes
				case ($urandom_range(0, 5))
					0: lo[31:16] = lo[15:0];
					1: hi[31:16] = hi[15:0];
					2: lo[15:8] = lo[7:0];
					default: ;
				endcase
				if (n == PHASE_BLOCKS / 2 && ph[0]) begin
					drain_pixels();
				end
				send_block(lo, hi, 1'b0, '0);
			end
		end

		drain_pixels();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
